/* sv/srl_pkg.sv */
`default_nettype none

package srl_pkg;

    // Sample, coefficient, step, position and configuration widths
    localparam int SAMPLE_BITS  = 24;
    localparam int GAIN_BITS    = 18;
    localparam int STEP_BITS    = 32;
    localparam int POS_BITS     = 32;
    localparam int FRAC_BITS    = 24;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    // Largest upsampling factor one input phase may produce
    localparam int MAX_UPSAMPLE = 16;

    // Position constants (Q8.24)
    localparam logic [POS_BITS:0]    POS_ONE  = (POS_BITS+1)'(64'd1 << FRAC_BITS);
    localparam logic [POS_BITS:0]    POS_TWO  = (POS_BITS+1)'(64'd2 << FRAC_BITS);
    localparam logic [STEP_BITS-1:0] MIN_STEP =
        STEP_BITS'(((64'd1 << FRAC_BITS) + 64'(MAX_UPSAMPLE) - 64'd1) / 64'(MAX_UPSAMPLE));

    // Projection shift and interpolation product and wide widths
    localparam int PROJ_SHIFT = 16;
    localparam int PROD_BITS  = 2 * (SAMPLE_BITS + 1);
    localparam int WIDE_BITS  = SAMPLE_BITS + 3;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_PLUS  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_CROSS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_RATIO = 2'd2;

    // Reset values of the registers
    localparam logic signed [GAIN_BITS-1:0] GAIN_PLUS_RST  = 18'sh10000;
    localparam logic signed [GAIN_BITS-1:0] GAIN_CROSS_RST = 18'sh00000;
    localparam logic [STEP_BITS-1:0]        STEP_RST       = 32'h0100_0000;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [WIDE_BITS-1:0]   t_wide;

    typedef struct packed {
        logic signed [GAIN_BITS-1:0] gain_plus;
        logic signed [GAIN_BITS-1:0] gain_cross;
        logic [STEP_BITS-1:0]        step_ratio;
    } t_cfg;

    // Projected sample waiting for the back end
    typedef struct packed {
        t_sample s;
        logic    last;
    } t_q_entry;

    // One output operation: base + round(diff * frac)
    typedef struct packed {
        logic                      valid;
        logic signed [SAMPLE_BITS:0] diff;
        logic [FRAC_BITS-1:0]      frac;
        t_sample                   base;
        logic                      run_end;
        logic                      stream_end;
    } t_op;

    // Clamp a wide signed value to the sample range
    function automatic t_sample sat_sample(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = WIDE_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
        lo = -hi - t_wide'(1);
        if (v > hi) begin
            sat_sample = hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            sat_sample = lo[SAMPLE_BITS-1:0];
        end else begin
            sat_sample = v[SAMPLE_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* sv/srl_in_if.sv */
`default_nettype none

interface srl_in_if;
    import srl_pkg::*;

    logic    valid;
    logic    ready;
    t_sample h_plus;
    t_sample h_cross;
    logic    last_in;

    modport source (output valid, output h_plus, output h_cross, output last_in,
                    input ready);
    modport sink   (input valid, input h_plus, input h_cross, input last_in,
                    output ready);
endinterface

`default_nettype wire

/* sv/srl_out_if.sv */
`default_nettype none

interface srl_out_if;
    import srl_pkg::*;

    logic    valid;
    logic    ready;
    t_sample strain_out;
    logic    run_end;
    logic    stream_end;

    modport source (output valid, output strain_out, output run_end, output stream_end,
                    input ready);
    modport sink   (input valid, input strain_out, input run_end, input stream_end,
                    output ready);
endinterface

`default_nettype wire

/* sv/srl_front.sv */
`default_nettype none

module srl_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    srl_in_if.sink                 i_in,
    input  wire srl_pkg::t_cfg     i_cfg,
    input  wire logic              i_full,
    output logic                   o_push,
    output srl_pkg::t_q_entry      o_wdata
);
    import srl_pkg::*;

    localparam int MUL_BITS = GAIN_BITS + SAMPLE_BITS;

    logic                       r_valid;
    logic signed [MUL_BITS-1:0] r_pp;
    logic signed [MUL_BITS-1:0] r_pc;
    logic                       r_last;
    logic                       w_en;
    logic signed [MUL_BITS:0]   w_acc;

    // Single product stage, stalls only while the queue is full
    assign w_en       = !r_valid || !i_full;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_in.valid) begin
            r_pp   <= i_cfg.gain_plus * i_in.h_plus;
            r_pc   <= i_cfg.gain_cross * i_in.h_cross;
            r_last <= i_in.last_in;
        end
    end

    // Sum, round half up, floor by 2^16, saturate
    assign w_acc = {r_pp[MUL_BITS-1], r_pp} + {r_pc[MUL_BITS-1], r_pc}
                 + (MUL_BITS+1)'(64'd1 << (PROJ_SHIFT - 1));

    assign o_push    = r_valid && !i_full;
    assign o_wdata.s = sat_sample(w_acc[MUL_BITS:PROJ_SHIFT]);
    assign o_wdata.last = r_last;

endmodule

`default_nettype wire

/* sv/srl_queue.sv */
`default_nettype none

module srl_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire srl_pkg::t_q_entry i_wdata,
    output logic                   o_full,
    input  wire logic              i_pop,
    output srl_pkg::t_q_entry      o_rdata,
    output logic                   o_empty
);
    import srl_pkg::*;

    t_q_entry        r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

/* sv/srl_seq.sv */
`default_nettype none

module srl_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire srl_pkg::t_cfg     i_cfg,
    input  wire logic              i_empty,
    input  wire srl_pkg::t_q_entry i_rdata,
    output logic                   o_pop,
    output srl_pkg::t_op           o_op
);
    import srl_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_INTERP = 2'd1;
    localparam logic [1:0] PH_HOLD   = 2'd2;

    logic [1:0]          r_phase, n_phase;
    t_sample             r_prev,  n_prev;
    logic [POS_BITS-1:0] r_pos,   n_pos;
    logic                r_have,  n_have;
    t_sample             r_cur_s, n_cur_s;
    logic                r_cur_last, n_cur_last;

    logic [STEP_BITS-1:0] w_step;
    logic [POS_BITS:0]    w_pos_n;
    logic                 w_in_phase;
    logic                 w_wrap;

    // Step clamped so one phase never exceeds the upsample limit
    assign w_step     = (i_cfg.step_ratio < MIN_STEP) ? MIN_STEP : i_cfg.step_ratio;
    assign w_pos_n    = {1'b0, r_pos} + (POS_BITS+1)'(w_step);
    assign w_in_phase = ({1'b0, r_pos} < POS_ONE);
    assign w_wrap     = (w_pos_n >= POS_ONE);

    always_comb begin
        n_phase    = r_phase;
        n_prev     = r_prev;
        n_pos      = r_pos;
        n_have     = r_have;
        n_cur_s    = r_cur_s;
        n_cur_last = r_cur_last;
        o_pop      = 1'b0;
        o_op       = '0;
        if (i_en) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (!i_empty) begin
                        o_pop      = 1'b1;
                        n_cur_s    = i_rdata.s;
                        n_cur_last = i_rdata.last;
                        if (!r_have) begin
                            // first sample of a waveform only loads the base
                            n_prev  = i_rdata.s;
                            n_pos   = '0;
                            n_have  = 1'b1;
                            n_phase = i_rdata.last ? PH_HOLD : PH_IDLE;
                        end else begin
                            n_phase = PH_INTERP;
                        end
                    end
                end
                PH_INTERP: begin
                    if (w_in_phase) begin
                        o_op.valid = 1'b1;
                        o_op.diff  = {r_cur_s[SAMPLE_BITS-1], r_cur_s}
                                   - {r_prev[SAMPLE_BITS-1], r_prev};
                        o_op.frac  = r_pos[FRAC_BITS-1:0];
                        o_op.base  = r_prev;
                        if (w_wrap) begin
                            // last interpolated output unless the hold tail emits
                            o_op.run_end    = !r_cur_last || (w_pos_n >= POS_TWO);
                            o_op.stream_end = r_cur_last && (w_pos_n >= POS_TWO);
                            n_pos   = POS_BITS'(w_pos_n - POS_ONE);
                            n_prev  = r_cur_s;
                            n_phase = r_cur_last ? PH_HOLD : PH_IDLE;
                        end else begin
                            n_pos = w_pos_n[POS_BITS-1:0];
                        end
                    end else begin
                        // position already beyond this interval
                        n_pos   = POS_BITS'({1'b0, r_pos} - POS_ONE);
                        n_prev  = r_cur_s;
                        n_phase = r_cur_last ? PH_HOLD : PH_IDLE;
                    end
                end
                PH_HOLD: begin
                    if (w_in_phase) begin
                        // repeat the final sample
                        o_op.valid      = 1'b1;
                        o_op.base       = r_cur_s;
                        o_op.run_end    = w_wrap;
                        o_op.stream_end = w_wrap;
                        n_pos           = w_pos_n[POS_BITS-1:0];
                    end
                    if (!w_in_phase || w_wrap) begin
                        n_prev  = '0;
                        n_pos   = '0;
                        n_have  = 1'b0;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_prev  <= '0;
            r_pos   <= '0;
            r_have  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_pos   <= n_pos;
            r_have  <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_s    <= n_cur_s;
        r_cur_last <= n_cur_last;
    end

endmodule

`default_nettype wire

/* sv/srl_interp.sv */
`default_nettype none

module srl_interp (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire srl_pkg::t_op i_op,
    output logic              o_en,
    srl_out_if.source         o_out
);
    import srl_pkg::*;

    t_op                         r_a;
    logic                        r_b_valid;
    logic signed [PROD_BITS-1:0] r_prod;
    t_sample                     r_b_base;
    logic                        r_b_run_end;
    logic                        r_b_stream_end;
    logic                        r_out_valid;
    t_sample                     r_out_s;
    logic                        r_out_run_end;
    logic                        r_out_stream_end;

    logic signed [PROD_BITS-1:0] w_rnd;
    t_wide                       w_v;

    // Whole back pipeline advances when the output register can move
    assign o_en = !r_out_valid || o_out.ready;

    // Operation register, multiply stage, round and saturate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_a.valid        <= i_op.valid;
            r_b_valid        <= r_a.valid;
            r_out_valid      <= r_b_valid;
            r_a.diff         <= i_op.diff;
            r_a.frac         <= i_op.frac;
            r_a.base         <= i_op.base;
            r_a.run_end      <= i_op.run_end;
            r_a.stream_end   <= i_op.stream_end;
            r_prod           <= r_a.diff * $signed({1'b0, r_a.frac});
            r_b_base         <= r_a.base;
            r_b_run_end      <= r_a.run_end;
            r_b_stream_end   <= r_a.stream_end;
            r_out_s          <= sat_sample(w_v);
            r_out_run_end    <= r_b_run_end;
            r_out_stream_end <= r_b_stream_end;
        end
    end

    // base + floor((diff*frac + 2^23) / 2^24)
    assign w_rnd = r_prod + PROD_BITS'(64'd1 << (FRAC_BITS - 1));
    assign w_v   = {{3{r_b_base[SAMPLE_BITS-1]}}, r_b_base}
                 + {w_rnd[PROD_BITS-1], w_rnd[PROD_BITS-1:FRAC_BITS]};

    assign o_out.valid      = r_out_valid;
    assign o_out.strain_out = r_out_s;
    assign o_out.run_end    = r_out_run_end;
    assign o_out.stream_end = r_out_stream_end;

endmodule

`default_nettype wire

/* sv/strain_project_linear_resample_top.sv */
`default_nettype none
// Channel   Dir  Handshake    Payload
// i_in      in   valid/ready  h_plus[23:0] h_cross[23:0] last_in
// o_out     out  valid/ready  strain_out[23:0] run_end stream_end
// i_cfg_*   in   write enable i_cfg_idx[1:0] i_cfg_data[31:0]
//
// The back sequencer produces at most one output item per cycle while the
// output is not stalled; each input item is first popped from the queue and
// then yields its outputs, with steps that emit nothing when an interval or the hold tail yields no output.
// An item's accepting edge loads the product stage; the queue, sequencer,
// operation, multiply and output registers follow before its outputs appear.
// Reset is synchronous, active low, and clears all control state at once.
// A full queue stalls the input; a stalled output freezes the back pipeline.
module strain_project_linear_resample_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    srl_in_if.sink                                   i_in,
    srl_out_if.source                                o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [srl_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [srl_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import srl_pkg::*;

    t_cfg     r_cfg;
    logic     w_full;
    logic     w_push;
    t_q_entry w_wdata;
    logic     w_pop;
    logic     w_empty;
    t_q_entry w_rdata;
    logic     w_en;
    t_op      w_op;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_plus  <= GAIN_PLUS_RST;
            r_cfg.gain_cross <= GAIN_CROSS_RST;
            r_cfg.step_ratio <= STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_PLUS:  r_cfg.gain_plus  <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_CROSS: r_cfg.gain_cross <= i_cfg_data[GAIN_BITS-1:0];
                CFG_STEP_RATIO: r_cfg.step_ratio <= i_cfg_data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    srl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_wdata (w_wdata)
    );

    srl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wdata),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_rdata),
        .o_empty (w_empty)
    );

    srl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_rdata (w_rdata),
        .o_pop   (w_pop),
        .o_op    (w_op)
    );

    srl_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .o_en    (w_en),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
